[hdl/assert_macros.svh]
// assertion macros used by the top level rtl file
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hdl/hrc_pkg.sv]
// shared types, constants and datapath op codes of the reprojection checker
// no dependencies
package hrc_pkg;

    localparam int COEF_W  = 32;
    localparam int COORD_W = 16;
    localparam int DIST_W  = 32;
    localparam int COUNT_W = 17;
    localparam int SUM_W   = 48;
    localparam int LIMIT_W = 24;
    localparam int NUM_REGS = 8;
    localparam int ADDR_W  = 5;

    localparam int DIST_LIMIT_DEF = 768;
    localparam int MAX_POINTS_DEF = 65536;

    localparam logic [COEF_W-1:0] COEF_ONE  = 32'd1048576;
    localparam logic [COEF_W-1:0] COEF_ZERO = 32'd0;

    // register indexes
    typedef enum logic [2:0] {
        REG_A = 3'd0, REG_B = 3'd1, REG_C = 3'd2, REG_D = 3'd3,
        REG_E = 3'd4, REG_F = 3'd5, REG_G = 3'd6, REG_H = 3'd7
    } reg_idx_t;

    typedef logic [NUM_REGS-1:0][COEF_W-1:0] coef_bank_t;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_GX, OP_HY, OP_Z, OP_ZCHK, OP_BY, OP_UZ, OP_EX,
        OP_EYM, OP_VZ, OP_EY, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END,
        OP_SQ_DX, OP_SQ_DY, OP_SQ_INIT, OP_SQRT_STEP, OP_FINISH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic sel_y;
    } cmd_t;

    typedef struct packed {
        logic degen;
        logic sat;
    } stat_t;

endpackage

[hdl/hrc_ctrl.sv]
// sequencer of the reprojection checker: steps the datapath through one request
// depends on hrc_pkg
module hrc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  hrc_pkg::stat_t stat,
    output hrc_pkg::cmd_t  cmd
);
    import hrc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_GX, S_HY, S_Z, S_ZCHK, S_BY, S_UZ, S_EX, S_EYM, S_VZ, S_EY,
        S_DIV_INIT, S_DIV_STEP, S_DIV_END, S_SQ_DX, S_SQ_DY, S_SQ_INIT,
        S_SQRT, S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       sel_y_reg, sel_y_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // next state and command
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sel_y_next     = sel_y_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = OP_NOP;
        cmd.sel_y      = sel_y_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    sel_y_next = 1'b0;
                    state_next = S_GX;
                end
            end
            S_GX:   begin cmd.op = OP_GX;   state_next = S_HY;   end
            S_HY:   begin cmd.op = OP_HY;   state_next = S_Z;    end
            S_Z:    begin cmd.op = OP_Z;    state_next = S_ZCHK; end
            S_ZCHK:
            begin
                cmd.op     = OP_ZCHK;
                state_next = stat.degen ? S_FINISH : S_BY;
            end
            S_BY:   begin cmd.op = OP_BY;   state_next = S_UZ;   end
            S_UZ:   begin cmd.op = OP_UZ;   state_next = S_EX;   end
            S_EX:   begin cmd.op = OP_EX;   state_next = S_EYM;  end
            S_EYM:  begin cmd.op = OP_EYM;  state_next = S_VZ;   end
            S_VZ:   begin cmd.op = OP_VZ;   state_next = S_EY;   end
            S_EY:   begin cmd.op = OP_EY;   state_next = S_DIV_INIT; end
            S_DIV_INIT:
            begin
                cmd.op   = OP_DIV_INIT;
                cnt_next = 5'd30;
                state_next = stat.sat ? S_FINISH : S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    state_next = S_DIV_END;
            end
            S_DIV_END:
            begin
                cmd.op = OP_DIV_END;
                if (sel_y_reg)
                    state_next = S_SQ_DX;
                else
                begin
                    sel_y_next = 1'b1;
                    state_next = S_DIV_INIT;
                end
            end
            S_SQ_DX: begin cmd.op = OP_SQ_DX; state_next = S_SQ_DY; end
            S_SQ_DY: begin cmd.op = OP_SQ_DY; state_next = S_SQ_INIT; end
            S_SQ_INIT:
            begin
                cmd.op     = OP_SQ_INIT;
                cnt_next   = 5'd31;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.op         = OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            sel_y_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sel_y_reg     <= sel_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hdl/hrc_dp.sv]
// datapath of the reprojection checker: shared multiplier, divider, square root, totals
// depends on hrc_pkg
module hrc_dp #(
    parameter int DIST_LIMIT = hrc_pkg::DIST_LIMIT_DEF,
    parameter int MAX_POINTS = hrc_pkg::MAX_POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hrc_pkg::cmd_t                       cmd,
    output hrc_pkg::stat_t                      stat,
    input  hrc_pkg::coef_bank_t                 coef,
    input  logic signed [hrc_pkg::COORD_W-1:0]  src_x,
    input  logic signed [hrc_pkg::COORD_W-1:0]  src_y,
    input  logic signed [hrc_pkg::COORD_W-1:0]  dst_x,
    input  logic signed [hrc_pkg::COORD_W-1:0]  dst_y,
    input  logic                                last_pair,
    output logic                                is_inlier,
    output logic [hrc_pkg::DIST_W-1:0]          distance,
    output logic                                degenerate,
    output logic [hrc_pkg::COUNT_W-1:0]         inlier_total,
    output logic [hrc_pkg::SUM_W-1:0]           distance_total,
    output logic                                set_done
);
    import hrc_pkg::*;

    localparam logic [DIST_W-1:0]  LIMIT_V = DIST_W'(DIST_LIMIT);
    localparam logic [COUNT_W-1:0] MAXP_V  = COUNT_W'(MAX_POINTS);

    // captured request
    logic signed [COORD_W-1:0] x_reg, y_reg, u_reg, v_reg;
    logic                      last_reg;
    // arithmetic state
    logic signed [63:0] prod_reg, acc_reg, ex_reg, ey_reg;
    logic signed [36:0] z20_reg;
    logic               degen_reg, sat_reg;
    logic [60:0]        rem_reg;
    logic [66:0]        dz_reg;
    logic [30:0]        q_reg, dx_reg, dy_reg;
    logic [63:0]        rad_reg, res_reg, bit_reg;
    // totals and result
    logic [COUNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic               inl_o_reg, degen_o_reg, last_o_reg;
    logic [DIST_W-1:0]  dist_o_reg;
    logic [COUNT_W-1:0] cnt_o_reg;
    logic [SUM_W-1:0]   sum_o_reg;

    logic signed [36:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [69:0] mul_p;
    logic signed [63:0] e_sel, e_mag;
    logic [60:0]        num;
    logic               over;
    logic [63:0]        sq_t;
    logic [DIST_W-1:0]  dist_w;
    logic               inl_w;
    logic [COUNT_W-1:0] cnt_w;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   sum_w;

    function automatic logic signed [36:0] ext_coef(input logic [COEF_W-1:0] c);
        ext_coef = {{5{c[COEF_W-1]}}, c};
    endfunction

    function automatic logic signed [32:0] ext_crd(input logic [COORD_W-1:0] c);
        ext_crd = {{17{c[COORD_W-1]}}, c};
    endfunction

    function automatic logic signed [63:0] ext_sh8(input logic [COEF_W-1:0] c);
        ext_sh8 = {{24{c[COEF_W-1]}}, c, 8'd0};
    endfunction

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_GX:    begin mul_a = ext_coef(coef[REG_G]); mul_b = ext_crd(x_reg); end
            OP_HY:    begin mul_a = ext_coef(coef[REG_H]); mul_b = ext_crd(y_reg); end
            OP_ZCHK:  begin mul_a = ext_coef(coef[REG_A]); mul_b = ext_crd(x_reg); end
            OP_BY:    begin mul_a = ext_coef(coef[REG_B]); mul_b = ext_crd(y_reg); end
            OP_UZ:    begin mul_a = z20_reg;               mul_b = ext_crd(u_reg); end
            OP_EX:    begin mul_a = ext_coef(coef[REG_D]); mul_b = ext_crd(x_reg); end
            OP_EYM:   begin mul_a = ext_coef(coef[REG_E]); mul_b = ext_crd(y_reg); end
            OP_VZ:    begin mul_a = z20_reg;               mul_b = ext_crd(v_reg); end
            OP_SQ_DX: begin mul_a = {6'd0, dx_reg};        mul_b = {2'd0, dx_reg}; end
            OP_SQ_DY: begin mul_a = {6'd0, dy_reg};        mul_b = {2'd0, dy_reg}; end
            default:  begin mul_a = '0;                    mul_b = '0;             end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // divider setup: rounded numerator and overflow check
    assign e_sel = cmd.sel_y ? ey_reg : ex_reg;
    assign e_mag = e_sel[63] ? -e_sel : e_sel;
    assign num   = {e_mag[52:0], 8'd0} + {25'd0, z20_reg[36:1]};
    assign over  = {7'd0, num} >= {z20_reg, 31'd0};

    assign stat.degen = acc_reg < 64'sd4096;
    assign stat.sat   = over;

    assign sq_t = res_reg + bit_reg;

    // result and totals
    assign dist_w  = (degen_reg || sat_reg) ? '1 : res_reg[DIST_W-1:0];
    assign inl_w   = dist_w <= LIMIT_V;
    assign cnt_w   = (inl_w && cnt_reg < MAXP_V) ? cnt_reg + 1'b1 : cnt_reg;
    assign sum_add = {1'b0, sum_reg} + {{(SUM_W+1-DIST_W){1'b0}}, dist_w};
    assign sum_w   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

    // arithmetic registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p[63:0];
        case (cmd.op)
            OP_LOAD:
            begin
                x_reg    <= src_x;
                y_reg    <= src_y;
                u_reg    <= dst_x;
                v_reg    <= dst_y;
                last_reg <= last_pair;
            end
            OP_HY:   acc_reg <= prod_reg + 64'sd4294967296;
            OP_Z:    acc_reg <= acc_reg + prod_reg;
            OP_ZCHK: z20_reg <= acc_reg[48:12];
            OP_BY:   acc_reg <= prod_reg;
            OP_UZ:   acc_reg <= acc_reg + prod_reg + ext_sh8(coef[REG_C]);
            OP_EX:   ex_reg  <= acc_reg - prod_reg;
            OP_EYM:  acc_reg <= prod_reg;
            OP_VZ:   acc_reg <= acc_reg + prod_reg + ext_sh8(coef[REG_F]);
            OP_EY:   ey_reg  <= acc_reg - prod_reg;
            OP_DIV_INIT:
            begin
                rem_reg <= num;
                dz_reg  <= {z20_reg, 30'd0};
                q_reg   <= '0;
            end
            OP_DIV_STEP:
            begin
                if ({6'd0, rem_reg} >= dz_reg)
                begin
                    rem_reg <= rem_reg - dz_reg[60:0];
                    q_reg   <= {q_reg[29:0], 1'b1};
                end
                else
                    q_reg   <= {q_reg[29:0], 1'b0};
                dz_reg <= dz_reg >> 1;
            end
            OP_DIV_END:
            begin
                if (cmd.sel_y)
                    dy_reg <= q_reg;
                else
                    dx_reg <= q_reg;
            end
            OP_SQ_DY: acc_reg <= prod_reg;
            OP_SQ_INIT:
            begin
                rad_reg <= acc_reg + prod_reg;
                res_reg <= '0;
                bit_reg <= 64'd1 << 62;
            end
            OP_SQRT_STEP:
            begin
                if (rad_reg >= sq_t)
                begin
                    rad_reg <= rad_reg - sq_t;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            OP_FINISH:
            begin
                inl_o_reg   <= inl_w;
                dist_o_reg  <= dist_w;
                degen_o_reg <= degen_reg;
                cnt_o_reg   <= cnt_w;
                sum_o_reg   <= sum_w;
                last_o_reg  <= last_reg;
            end
            default: ;
        endcase
    end

    // flags and running totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degen_reg <= 1'b0;
            sat_reg   <= 1'b0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    degen_reg <= 1'b0;
                    sat_reg   <= 1'b0;
                end
                OP_ZCHK:     degen_reg <= stat.degen;
                OP_DIV_INIT: sat_reg   <= over;
                OP_FINISH:
                begin
                    cnt_reg <= last_reg ? '0 : cnt_w;
                    sum_reg <= last_reg ? '0 : sum_w;
                end
                default: ;
            endcase
        end
    end

    assign is_inlier      = inl_o_reg;
    assign distance       = dist_o_reg;
    assign degenerate     = degen_o_reg;
    assign inlier_total   = cnt_o_reg;
    assign distance_total = sum_o_reg;
    assign set_done       = last_o_reg;

endmodule

[hdl/homography_reprojection_checker_unit.sv]
// channel   direction  handshake             payload
// in        receive    in_valid / in_stall   src_x src_y dst_x dst_y last_pair
// out       send       out_valid / out_stall is_inlier distance degenerate totals set_done
// cfg       apb r/w    psel penable pwrite   paddr pwdata -> prdata
//
// a request keeps the input busy until its result is finished. a degenerate request ends
// after the z check, a saturated x or y error ends at that division's setup, and otherwise
// one 31-step restoring divider used twice and a 32-step bit-serial square root set the busy time.
// the finish state waits while the previous result is still held under out_stall.
// reset (rst_n low, asynchronous) restores the identity map and clears the totals.
// a new request is taken while a finished result waits under out_stall.
// depends on hrc_pkg, hrc_ctrl, hrc_dp and assert_macros.svh
`include "assert_macros.svh"
module homography_reprojection_checker_unit #(
    parameter int DIST_LIMIT = hrc_pkg::DIST_LIMIT_DEF,
    parameter int MAX_POINTS = hrc_pkg::MAX_POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [hrc_pkg::COORD_W-1:0]  src_x,
    input  logic signed [hrc_pkg::COORD_W-1:0]  src_y,
    input  logic signed [hrc_pkg::COORD_W-1:0]  dst_x,
    input  logic signed [hrc_pkg::COORD_W-1:0]  dst_y,
    input  logic                                last_pair,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                is_inlier,
    output logic [hrc_pkg::DIST_W-1:0]          distance,
    output logic                                degenerate,
    output logic [hrc_pkg::COUNT_W-1:0]         inlier_total,
    output logic [hrc_pkg::SUM_W-1:0]           distance_total,
    output logic                                set_done,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hrc_pkg::ADDR_W-1:0]          paddr,
    input  logic [hrc_pkg::COEF_W-1:0]          pwdata,
    output logic [hrc_pkg::COEF_W-1:0]          prdata,
    output logic                                pready
);
    import hrc_pkg::*;

    coef_bank_t coef_reg;
    cmd_t       cmd;
    stat_t      stat;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1:2];
    assign prdata  = coef_reg[reg_sel];

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // identity map: a and e at one, everything else zero
            coef_reg <= {COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE,
                         COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE};
        end
        else if (psel && penable && pwrite)
            coef_reg[reg_sel] <= pwdata;
    end

    hrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    hrc_dp #(
        .DIST_LIMIT (DIST_LIMIT),
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .coef           (coef_reg),
        .src_x          (src_x),
        .src_y          (src_y),
        .dst_x          (dst_x),
        .dst_y          (dst_y),
        .last_pair      (last_pair),
        .is_inlier      (is_inlier),
        .distance       (distance),
        .degenerate     (degenerate),
        .inlier_total   (inlier_total),
        .distance_total (distance_total),
        .set_done       (set_done)
    );

    // a taken request keeps the input side busy
    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall)
    // a degenerate result is saturated and never an inlier
    `ASSERT_IMPL(a_degen_sat, clk, rst_n, out_valid && degenerate, distance == '1 && !is_inlier)
    // the inlier count never passes its limit
    `ASSERT_IMPL(a_count_cap, clk, rst_n, out_valid, inlier_total <= COUNT_W'(MAX_POINTS))

endmodule
